FILE: src/psts_pkg.sv
// Shared types and constants for the price series trend statistics block.
// No dependencies; imported by every module under src.
package psts_pkg;

    localparam int PRICE_W = 24;
    localparam int NET_W   = 25;
    localparam int SUM_W   = 27;
    localparam int WIN_W   = 3;
    localparam int DAYO_W  = 3;
    localparam int TREND_W = 3;
    localparam int QUAL_W  = 2;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [WIN_W-1:0] WIN_RESET = 3'd7;

    // Register index, taken from paddr[2] (word address)
    localparam logic REG_WINDOW_LEN = 1'b0;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic [TREND_W-1:0] {
        TREND_STRONG_UP   = 3'd0,
        TREND_STRONG_DOWN = 3'd1,
        TREND_FLAT        = 3'd2,
        TREND_OVERALL_UP  = 3'd3,
        TREND_OVERALL_DN  = 3'd4,
        TREND_MIXED       = 3'd5
    } trend_t;

    typedef enum logic [QUAL_W-1:0] {
        QUAL_GOOD  = 2'd0,
        QUAL_BAD   = 2'd1,
        QUAL_MIXED = 2'd2
    } quality_t;

    // One finished series, handed from the front end to the divider
    typedef struct packed {
        trend_t               trend;
        quality_t             quality;
        logic [NET_W-1:0]     net;
        logic [PRICE_W-1:0]   profit;
        logic [DAYO_W-1:0]    buy_day;
        logic [DAYO_W-1:0]    exit_day;
        logic                 has_profit;
        logic [SUM_W-1:0]     wsum;
        logic [WIN_W-1:0]     divisor;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

FILE: src/price_series_trend_stats.sv
// Result path: with the back end idle, the closing sample of a series is pushed into
// the job queue and popped in ST_IDLE, going straight to ST_DONE (result_valid)
// when window_len is 0, else after 27 ST_RUN steps (one quotient bit per cycle).
// Throughput: one sample beat per cycle; the back end takes one series at a time, so
// with short series the closing beat stalls once the two-entry job queue is full.
// Reset (rst_n, async, active low) clears the day counter, statistics, queue
// pointers and back-end state; window_len resets to 7.
// Top level of the price series trend statistics block.
// Depends on psts_pkg, psts_front, psts_queue and psts_back.
module price_series_trend_stats #(
    parameter int SERIES_LEN = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB-style configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [psts_pkg::ADDR_W-1:0]   paddr,
    input  logic [psts_pkg::DATA_W-1:0]   pwdata,
    output logic [psts_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // Sample channel
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic [psts_pkg::PRICE_W-1:0]  price_sample,
    // Result channel
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [psts_pkg::TREND_W-1:0]  trend_class,
    output logic [psts_pkg::QUAL_W-1:0]   quality_class,
    output logic [psts_pkg::NET_W-1:0]    net_change,
    output logic [psts_pkg::PRICE_W-1:0]  max_profit,
    output logic [psts_pkg::DAYO_W-1:0]   buy_day,
    output logic [psts_pkg::DAYO_W-1:0]   exit_day,
    output logic                          has_profit,
    output logic [psts_pkg::PRICE_W-1:0]  moving_avg
);
    import psts_pkg::*;

    logic [WIN_W-1:0] window_len_reg;
    logic             cfg_write;
    logic             push;
    logic             pop;
    job_t             push_job;
    job_t             head_job;
    q_stat_t          q_stat;

    // Configuration: single register, word address 0, zero wait states.
    // Writes land in the access phase; other word addresses read as zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_len_reg <= WIN_RESET;
        else if (cfg_write)
            window_len_reg <= pwdata[WIN_W-1:0];
    end

    assign prdata = (paddr[2] == REG_WINDOW_LEN) ? DATA_W'(window_len_reg) : '0;

    // Front end: track the series one beat per cycle and emit a job on its
    // closing beat. It only back-pressures when that job finds no queue slot.
    psts_front #(
        .SERIES_LEN (SERIES_LEN)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .price_sample (price_sample),
        .window_len   (window_len_reg),
        .q_stat       (q_stat),
        .push         (push),
        .job          (push_job)
    );

    // Queue: decouple sample intake from the divide and result handshake
    psts_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    // Back end: finish the moving average and hold the result beat until taken
    psts_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_job      (head_job),
        .q_stat        (q_stat),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .trend_class   (trend_class),
        .quality_class (quality_class),
        .net_change    (net_change),
        .max_profit    (max_profit),
        .buy_day       (buy_day),
        .exit_day      (exit_day),
        .has_profit    (has_profit),
        .moving_avg    (moving_avg)
    );

endmodule

FILE: src/psts_front.sv
// Front end: accepts price beats, keeps the running series statistics and
// pushes one job per finished series into the queue. Depends on psts_pkg.
module psts_front #(
    parameter int SERIES_LEN = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic [psts_pkg::PRICE_W-1:0]  price_sample,
    input  logic [psts_pkg::WIN_W-1:0]    window_len,
    input  psts_pkg::q_stat_t             q_stat,
    output logic                          push,
    output psts_pkg::job_t                job
);
    import psts_pkg::*;

    localparam int DAY_W = (SERIES_LEN > 1) ? $clog2(SERIES_LEN) : 1;
    localparam int SW    = ((DAY_W > WIN_W) ? DAY_W : WIN_W) + 1;
    localparam int CAP   = (SERIES_LEN < 7) ? SERIES_LEN : 7;
    localparam logic [WIN_W-1:0] LEN_CAP = WIN_W'(CAP);
    localparam logic [DAY_W-1:0] LAST    = DAY_W'(SERIES_LEN - 1);
    localparam logic [SW-1:0]    LEN_SW  = SW'(SERIES_LEN);

    logic [DAY_W-1:0]   day_reg, day_next;
    logic [PRICE_W-1:0] first_reg, first_next;
    logic [PRICE_W-1:0] prev_reg;
    logic [DAY_W-1:0]   up_reg, up_next;
    logic [DAY_W-1:0]   down_reg, down_next;
    logic [DAY_W-1:0]   eq_reg, eq_next;
    logic [PRICE_W-1:0] rmin_reg, rmin_next;
    logic [DAY_W-1:0]   rmin_day_reg, rmin_day_next;
    logic [PRICE_W-1:0] profit_reg, profit_next;
    logic [DAY_W-1:0]   buy_reg, buy_next;
    logic [DAY_W-1:0]   sell_reg, sell_next;
    logic [SUM_W-1:0]   wsum_reg, wsum_next;

    logic               accept;
    logic               is_first;
    logic               is_last;
    logic [WIN_W-1:0]   eff_win;
    logic [SW-1:0]      day_plus_win;
    logic               in_window;
    logic [PRICE_W-1:0] gain;
    logic               gain_better;
    logic [DAY_W+2:0]   buy_ext;
    logic [DAY_W+2:0]   sell_ext;
    trend_t             trend;
    quality_t           quality;

    assign is_first = (day_reg == '0);
    assign is_last  = (day_reg == LAST);

    // Stall only on the closing beat of a series when the queue has no room
    assign sample_ready = !is_last || !q_stat.full;
    assign accept       = sample_valid && sample_ready;
    assign push         = accept && is_last;

    assign eff_win      = (window_len > LEN_CAP) ? LEN_CAP : window_len;
    assign day_plus_win = SW'(day_reg) + SW'(eff_win);
    assign in_window    = (eff_win != '0) && (day_plus_win >= LEN_SW);

    assign gain        = price_sample - rmin_reg;
    assign gain_better = (price_sample > rmin_reg) && (gain > profit_reg);

    always_comb
    begin
        day_next      = is_last ? '0 : day_reg + DAY_W'(1);
        first_next    = is_first ? price_sample : first_reg;
        up_next       = '0;
        down_next     = '0;
        eq_next       = '0;
        rmin_next     = price_sample;
        rmin_day_next = '0;
        profit_next   = '0;
        buy_next      = '0;
        sell_next     = '0;
        wsum_next     = in_window ? SUM_W'(price_sample) : '0;
        if (!is_first)
        begin
            up_next   = up_reg   + DAY_W'(price_sample > prev_reg);
            down_next = down_reg + DAY_W'(price_sample < prev_reg);
            eq_next   = eq_reg   + DAY_W'(price_sample == prev_reg);
            profit_next = gain_better ? gain : profit_reg;
            buy_next    = gain_better ? rmin_day_reg : buy_reg;
            sell_next   = gain_better ? day_reg : sell_reg;
            rmin_next     = (price_sample < rmin_reg) ? price_sample : rmin_reg;
            rmin_day_next = (price_sample < rmin_reg) ? day_reg : rmin_day_reg;
            wsum_next = wsum_reg + (in_window ? SUM_W'(price_sample) : '0);
        end
    end

    always_comb
    begin
        if (up_next == LAST)
            trend = TREND_STRONG_UP;
        else if (down_next == LAST)
            trend = TREND_STRONG_DOWN;
        else if (eq_next == LAST)
            trend = TREND_FLAT;
        else if (up_next > down_next)
            trend = TREND_OVERALL_UP;
        else if (down_next > up_next)
            trend = TREND_OVERALL_DN;
        else
            trend = TREND_MIXED;

        if ((price_sample > first_reg) && (up_next > down_next))
            quality = QUAL_GOOD;
        else if ((price_sample < first_reg) && (down_next > up_next))
            quality = QUAL_BAD;
        else
            quality = QUAL_MIXED;
    end

    // Day numbers leave as their low three bits
    assign buy_ext  = {3'b000, buy_next};
    assign sell_ext = {3'b000, sell_next};

    always_comb
    begin
        job.trend      = trend;
        job.quality    = quality;
        job.net        = NET_W'(price_sample) - NET_W'(first_reg);
        job.profit     = profit_next;
        job.buy_day    = buy_ext[2:0];
        job.exit_day   = sell_ext[2:0];
        job.has_profit = (profit_next != '0);
        job.wsum       = wsum_next;
        job.divisor    = eff_win;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg      <= '0;
            first_reg    <= '0;
            prev_reg     <= '0;
            up_reg       <= '0;
            down_reg     <= '0;
            eq_reg       <= '0;
            rmin_reg     <= '0;
            rmin_day_reg <= '0;
            profit_reg   <= '0;
            buy_reg      <= '0;
            sell_reg     <= '0;
            wsum_reg     <= '0;
        end
        else if (accept)
        begin
            day_reg      <= day_next;
            first_reg    <= first_next;
            prev_reg     <= price_sample;
            up_reg       <= up_next;
            down_reg     <= down_next;
            eq_reg       <= eq_next;
            rmin_reg     <= rmin_next;
            rmin_day_reg <= rmin_day_next;
            profit_reg   <= profit_next;
            buy_reg      <= buy_next;
            sell_reg     <= sell_next;
            wsum_reg     <= wsum_next;
        end
    end

    // A pushed series always wraps the day counter
    assert property (@(posedge clk) disable iff (!rst_n) push |=> (day_reg == '0))
        else $error("day counter did not wrap after series end");

    // Any recorded profit sells strictly after it buys
    assert property (@(posedge clk) disable iff (!rst_n)
        (profit_reg != '0) |-> (sell_reg > buy_reg))
        else $error("profit recorded with sell day not after buy day");

endmodule

FILE: src/psts_queue.sv
// Short job queue between the front end and the divider back end.
// Depends on psts_pkg for job_t, q_stat_t and the depth.
module psts_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  psts_pkg::job_t    push_job,
    input  logic              pop,
    output psts_pkg::job_t    head_job,
    output psts_pkg::q_stat_t q_stat
);
    import psts_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_job     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + QPTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + QPTR_W'(1);
        count_next = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

FILE: src/psts_back.sv
// Back end: pops a job, divides the window sum by the window length one
// quotient bit per cycle and holds the result beat. Depends on psts_pkg.
module psts_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  psts_pkg::job_t                head_job,
    input  psts_pkg::q_stat_t             q_stat,
    output logic                          pop,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [psts_pkg::TREND_W-1:0]  trend_class,
    output logic [psts_pkg::QUAL_W-1:0]   quality_class,
    output logic [psts_pkg::NET_W-1:0]    net_change,
    output logic [psts_pkg::PRICE_W-1:0]  max_profit,
    output logic [psts_pkg::DAYO_W-1:0]   buy_day,
    output logic [psts_pkg::DAYO_W-1:0]   exit_day,
    output logic                          has_profit,
    output logic [psts_pkg::PRICE_W-1:0]  moving_avg
);
    import psts_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic [WIN_W-1:0]   rem_reg, rem_next;
    logic [WIN_W-1:0]   div_reg, div_next;
    job_t               job_reg, job_next;
    logic [WIN_W:0]     trial;
    logic               fits;

    assign pop = (state_reg == ST_IDLE) && !q_stat.empty;

    // One restoring step: bring down the next dividend bit
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        job_next   = job_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    job_next = head_job;
                    div_next = head_job.divisor;
                    rem_next = '0;
                    cnt_next = CNT_W'(SUM_W - 1);
                    if (head_job.divisor == '0)
                    begin
                        quo_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        quo_next   = head_job.wsum;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                rem_next = fits ? WIN_W'(trial - {1'b0, div_reg}) : trial[WIN_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], fits};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (result_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        job_reg <= job_next;
    end

    assign result_valid  = (state_reg == ST_DONE);
    assign trend_class   = job_reg.trend;
    assign quality_class = job_reg.quality;
    assign net_change    = job_reg.net;
    assign max_profit    = job_reg.profit;
    assign buy_day       = job_reg.buy_day;
    assign exit_day      = job_reg.exit_day;
    assign has_profit    = job_reg.has_profit;
    assign moving_avg    = quo_reg[PRICE_W-1:0];

    // Partial remainder stays below the divisor through every step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (rem_reg < div_reg))
        else $error("divider remainder out of range");

    // A popped job always starts a division or goes straight to the result
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == ST_RUN || state_reg == ST_DONE))
        else $error("popped job was dropped");

endmodule

FILE: tb/price_series_trend_stats_tb.sv
// Self-checking testbench for price_series_trend_stats: random and directed sample beats,
// APB window writes, and a per-series predictor of trend, quality, profit and moving average.
// Depends on psts_pkg and the price_series_trend_stats RTL only.
module price_series_trend_stats_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psts_pkg::*;

    localparam int SERIES_LEN    = 7;
    localparam int DRAIN_CYCLES  = 40;
    localparam int END_WAIT_MAX  = 20000;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASE_SAMPLES = 170;
    localparam logic [ADDR_W-1:0]  WINDOW_LEN_ADDR = {REG_WINDOW_LEN, 2'b00};
    localparam logic [PRICE_W-1:0] PRICE_MAX       = '1;

    // Price shapes for one random series
    typedef enum int {
        SHAPE_UNIFORM,
        SHAPE_NARROW,
        SHAPE_WALK,
        SHAPE_EXTREME
    } price_shape_t;

    typedef struct packed {
        trend_t               trend;
        quality_t             quality;
        logic [NET_W-1:0]     net;
        logic [PRICE_W-1:0]   profit;
        logic [DAYO_W-1:0]    buy_day;
        logic [DAYO_W-1:0]    exit_day;
        logic                 has_profit;
        logic [PRICE_W-1:0]   avg;
    } series_stats_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 sample_valid;
    logic                 sample_ready;
    logic [PRICE_W-1:0]   price_sample;
    logic                 result_valid;
    logic                 result_ready;
    logic [TREND_W-1:0]   trend_class;
    logic [QUAL_W-1:0]    quality_class;
    logic [NET_W-1:0]     net_change;
    logic [PRICE_W-1:0]   max_profit;
    logic [DAYO_W-1:0]    buy_day;
    logic [DAYO_W-1:0]    exit_day;
    logic                 has_profit;
    logic [PRICE_W-1:0]   moving_avg;

    price_series_trend_stats #(
        .SERIES_LEN(SERIES_LEN)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .price_sample (price_sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .trend_class  (trend_class),
        .quality_class(quality_class),
        .net_change   (net_change),
        .max_profit   (max_profit),
        .buy_day      (buy_day),
        .exit_day     (exit_day),
        .has_profit   (has_profit),
        .moving_avg   (moving_avg)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the series statistics.
    // ------------------------------------------------------------------
    logic [WIN_W-1:0]     cur_window;
    logic [DAYO_W-1:0]    day_no;
    logic [PRICE_W-1:0]   open_price;
    logic [PRICE_W-1:0]   last_price;
    logic [DAYO_W-1:0]    ups;
    logic [DAYO_W-1:0]    downs;
    logic [DAYO_W-1:0]    flats;
    logic [PRICE_W-1:0]   low_price;
    logic [DAYO_W-1:0]    low_day;
    logic [PRICE_W-1:0]   top_gain;
    logic [DAYO_W-1:0]    gain_buy;
    logic [DAYO_W-1:0]    gain_sell;
    logic [SUM_W-1:0]     tail_sum;

    series_stats_t        stats_due_q[$];

    // Bookkeeping
    int                   error_count;
    int                   mismatch_count;
    int                   samples_sent;
    int                   series_closed;
    int                   results_seen;
    logic [7:0]           windows_written;

    // Idle profile of both sides, in percent per beat
    int                   send_gap_pct;
    int                   ready_stall_pct;
    int                   ready_hold;

    // Per-series random shape
    price_shape_t         series_shape;
    logic [PRICE_W-1:0]   series_base;
    int                   walk_up_pct;

    // ------------------------------------------------------------------
    // Clock and limit
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Global timeout, set far beyond the worst correct run.
    initial
    begin
        #2_000_000;
        $display("Timeout: %0d results still outstanding", stats_due_q.size());
        $display("FAIL price_series_trend_stats");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int effective_window();
        return (int'(cur_window) > SERIES_LEN) ? SERIES_LEN : int'(cur_window);
    endfunction

    // Fold one accepted price into the statistics; queue a result on the closing day.
    task automatic absorb_price(input logic [PRICE_W-1:0] p);
        int                 k;
        bit                 in_tail;
        logic [SUM_W-1:0]   quotient;
        series_stats_t      s;
        begin
            k       = effective_window();
            in_tail = (k > 0) && (int'(day_no) >= SERIES_LEN - k);

            if (day_no == 0)
            begin
                // Open a new series: open and low price take this price, the other statistics clear
                open_price = p;
                low_price  = p;
                low_day    = '0;
                top_gain   = '0;
                gain_buy   = '0;
                gain_sell  = '0;
                ups        = '0;
                downs      = '0;
                flats      = '0;
                tail_sum   = '0;
            end
            else
            begin
                if (p > last_price)
                    ups = ups + 1'b1;
                else if (p < last_price)
                    downs = downs + 1'b1;
                else
                    flats = flats + 1'b1;

                // A sell only counts when it strictly beats the best gain so far
                if (p > low_price && (p - low_price) > top_gain)
                begin
                    top_gain  = p - low_price;
                    gain_buy  = low_day;
                    gain_sell = day_no;
                end
                // The minimum only moves on a strictly lower price
                if (p < low_price)
                begin
                    low_price = p;
                    low_day   = day_no;
                end
            end
            last_price = p;
            if (in_tail)
                tail_sum = tail_sum + SUM_W'(p);

            if (int'(day_no) + 1 < SERIES_LEN)
            begin
                day_no = day_no + 1'b1;
            end
            else
            begin
                day_no = '0;

                if (int'(ups) == SERIES_LEN - 1)
                    s.trend = TREND_STRONG_UP;
                else if (int'(downs) == SERIES_LEN - 1)
                    s.trend = TREND_STRONG_DOWN;
                else if (int'(flats) == SERIES_LEN - 1)
                    s.trend = TREND_FLAT;
                else if (ups > downs)
                    s.trend = TREND_OVERALL_UP;
                else if (downs > ups)
                    s.trend = TREND_OVERALL_DN;
                else
                    s.trend = TREND_MIXED;

                if (p > open_price && ups > downs)
                    s.quality = QUAL_GOOD;
                else if (p < open_price && downs > ups)
                    s.quality = QUAL_BAD;
                else
                    s.quality = QUAL_MIXED;

                // Divisor uses the window in force at the closing sample
                k        = effective_window();
                quotient = (k > 0) ? tail_sum / SUM_W'(k) : '0;

                s.net        = {1'b0, p} - {1'b0, open_price};
                s.profit     = top_gain;
                s.buy_day    = gain_buy;
                s.exit_day   = gain_sell;
                s.has_profit = (top_gain != '0);
                s.avg        = quotient[PRICE_W-1:0];
                stats_due_q.push_back(s);
                series_closed++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: pop the oldest expectation on every result beat.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        series_stats_t got;
        series_stats_t want;
        if (rst_n && result_valid && result_ready)
        begin
            got.trend      = trend_t'(trend_class);
            got.quality    = quality_t'(quality_class);
            got.net        = net_change;
            got.profit     = max_profit;
            got.buy_day    = buy_day;
            got.exit_day   = exit_day;
            got.has_profit = has_profit;
            got.avg        = moving_avg;
            results_seen++;
            if (stats_due_q.size() == 0)
            begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: result beat with nothing expected", $realtime);
            end
            else
            begin
                want = stats_due_q.pop_front();
                if (got.trend !== want.trend || got.quality !== want.quality ||
                    got.net !== want.net || got.profit !== want.profit ||
                    got.buy_day !== want.buy_day || got.exit_day !== want.exit_day ||
                    got.has_profit !== want.has_profit || got.avg !== want.avg)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: result %0d mismatch", $realtime, results_seen);
                        $display("  exp trend=%0d qual=%0d net=%h profit=%h",
                                 want.trend, want.quality, want.net, want.profit);
                        $display("      buy=%0d sell=%0d has=%b avg=%h",
                                 want.buy_day, want.exit_day, want.has_profit, want.avg);
                        $display("  got trend=%0d qual=%0d net=%h profit=%h",
                                 got.trend, got.quality, got.net, got.profit);
                        $display("      buy=%0d sell=%0d has=%b avg=%h",
                                 got.buy_day, got.exit_day, got.has_profit, got.avg);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Idle generation
    // ------------------------------------------------------------------
    // Most gaps are short; roughly 15 percent are long.
    function automatic int pick_gap();
        if ($urandom_range(99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // Receiver: hold ready low for a random stretch, then release.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            ready_hold = 0;
            result_ready <= 1'b0;
        end
        else if (ready_hold > 0)
        begin
            ready_hold = ready_hold - 1;
            result_ready <= 1'b0;
        end
        else if ($urandom_range(99) < ready_stall_pct)
        begin
            ready_hold = pick_gap() - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sample channel and configuration port
    // ------------------------------------------------------------------
    // Send one sample beat. Valid stays high across back-to-back beats; the
    // first negedge after acceptance either loads the next price or drops valid.
    task automatic send_price(input logic [PRICE_W-1:0] p);
        int gap;
        begin
            gap = ($urandom_range(99) < send_gap_pct) ? pick_gap() : 0;
            @(negedge clk);
            if (gap > 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            sample_valid <= 1'b1;
            price_sample <= p;
            do
                @(posedge clk);
            while (!sample_ready);
            absorb_price(p);
            samples_sent++;
        end
    endtask

    // Drop valid, wait for every expected result, then let the divider settle.
    task automatic drain_results();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (stats_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WINDOW_LEN_ADDR;
        pwdata  <= DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        cur_window             = value;
        windows_written[value] = 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Read the window back and compare with the predictor's copy.
    task automatic check_window_readback();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= WINDOW_LEN_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== DATA_W'(cur_window))
        begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t: window readback exp=%h got=%h", $realtime,
                         DATA_W'(cur_window), prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random price source
    // ------------------------------------------------------------------
    task automatic start_series_shape();
        series_shape = price_shape_t'($urandom_range(0, 3));
        case ($urandom_range(0, 2))
            0:       series_base = '0;
            1:       series_base = PRICE_MAX - PRICE_W'(3);
            default: series_base = PRICE_W'($urandom_range(0, 32'hFFFFFC));
        endcase
        walk_up_pct = $urandom_range(0, 100);
    endtask

    function automatic logic [PRICE_W-1:0] next_price();
        logic [PRICE_W-1:0] step;
        int                 r;
        begin
            case (series_shape)
                SHAPE_UNIFORM:
                    return PRICE_W'($urandom());
                SHAPE_NARROW:
                    // Few distinct values: plenty of equal steps and ties
                    return series_base + PRICE_W'($urandom_range(0, 3));
                SHAPE_WALK:
                begin
                    step = PRICE_W'($urandom_range(0, 15));
                    r    = $urandom_range(0, 109);
                    if (r < walk_up_pct)
                        return (last_price > PRICE_MAX - step) ? PRICE_MAX : last_price + step;
                    else if (r < 100)
                        return (last_price < step) ? '0 : last_price - step;
                    return last_price;
                end
                default:
                    case ($urandom_range(0, 3))
                        0:       return '0;
                        1:       return PRICE_W'(1);
                        2:       return PRICE_MAX - PRICE_W'(1);
                        default: return PRICE_MAX;
                    endcase
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset value readback, a window write of 7 with readback, then a strictly rising
    // and a strictly falling series spanning the full price range.
    task automatic test_range_extremes();
        logic [PRICE_W-1:0] rising  [SERIES_LEN];
        logic [PRICE_W-1:0] falling [SERIES_LEN];
        begin
            rising  = '{24'd0, 24'd1, 24'd2, 24'd3, 24'd4, 24'd5, 24'hFFFFFF};
            falling = '{24'hFFFFFF, 24'hFFFFFE, 24'hFFFFFD, 24'hFFFFFC,
                        24'hFFFFFB, 24'hFFFFFA, 24'd0};
            send_gap_pct    = 0;
            ready_stall_pct = 0;
            check_window_readback();
            write_window(3'd7);
            check_window_readback();
            foreach (rising[i])
                send_price(rising[i]);
            foreach (falling[i])
                send_price(falling[i]);
            drain_results();
        end
    endtask

    // Window of zero on a flat series, then a window changed mid-series
    // on a mixed series with a tied later peak.
    task automatic test_window_edges();
        logic [PRICE_W-1:0] wavy [SERIES_LEN];
        begin
            wavy = '{24'd100, 24'd200, 24'd100, 24'd200, 24'd100, 24'd100, 24'd100};
            write_window(3'd0);
            check_window_readback();
            repeat (SERIES_LEN)
                send_price(24'h5A5A5A);
            drain_results();

            write_window(3'd2);
            for (int i = 0; i < 3; i++)
                send_price(wavy[i]);
            // Open series: widen the window for the remaining days
            drain_results();
            write_window(3'd5);
            for (int i = 3; i < SERIES_LEN; i++)
                send_price(wavy[i]);
            drain_results();
        end
    endtask

    // One random phase: set the window while idle, then stream shaped series.
    // The sample count is usually not a multiple of the series length, so the next
    // window write often lands inside an open series.
    task automatic test_random_phase(input logic [WIN_W-1:0] win, input int gap_pct,
                                     input int stall_pct, input bit pause_midway);
        int n;
        begin
            n = PHASE_SAMPLES + $urandom_range(0, SERIES_LEN - 1);
            drain_results();
            write_window(win);
            check_window_readback();
            send_gap_pct    = gap_pct;
            ready_stall_pct = stall_pct;
            for (int i = 0; i < n; i++)
            begin
                if (day_no == 0)
                    start_series_shape();
                send_price(next_price());
                // Hold the sender until every outstanding result is back
                if (pause_midway && i == n / 2)
                    drain_results();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int waited;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        sample_valid    = 1'b0;
        price_sample    = '0;
        send_gap_pct    = 0;
        ready_stall_pct = 0;
        error_count     = 0;
        mismatch_count  = 0;
        samples_sent    = 0;
        series_closed   = 0;
        results_seen    = 0;
        windows_written = '0;
        series_shape    = SHAPE_UNIFORM;
        series_base     = '0;
        walk_up_pct     = 50;

        // Predictor mirrors the reset state
        cur_window = WIN_RESET;
        day_no     = '0;
        open_price = '0;
        last_price = '0;
        ups        = '0;
        downs      = '0;
        flats      = '0;
        low_price  = '0;
        low_day    = '0;
        top_gain   = '0;
        gain_buy   = '0;
        gain_sell  = '0;
        tail_sum   = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_range_extremes();
        test_window_edges();
        test_random_phase(3'd7, 0, 0, 1'b0);                          // no idling
        test_random_phase(3'd1, 40, 5, 1'b0);                         // sender idles
        test_random_phase(3'd0, 5, 50, 1'b1);                         // receiver stalls
        test_random_phase(3'd4, 20, 20, 1'b1);
        test_random_phase(3'd2, 10, 30, 1'b0);
        test_random_phase(WIN_W'($urandom_range(1, 7)), 25, 10, 1'b0);

        // Drop valid and wait out every outstanding result
        @(negedge clk);
        sample_valid <= 1'b0;
        waited = 0;
        while (stats_due_q.size() != 0 && waited < END_WAIT_MAX)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (stats_due_q.size() != 0)
        begin
            error_count += stats_due_q.size();
            $display("%0d expected results never arrived", stats_due_q.size());
        end

        $display("Covered %0d sample beats in %0d closed series, %0d result beats checked",
                 samples_sent, series_closed, results_seen);
        $display("Window lengths written (bit per value): %b; %0d errors",
                 windows_written, error_count);
        if (error_count == 0)
            $display("PASS price_series_trend_stats");
        else
            $display("FAIL price_series_trend_stats");
        $finish;
    end

endmodule
